// ----- rtl/core/bgi_pkg.sv -----
// Package: sizes, commands, sequencer states and helpers for bilinear grid interpolation.
`default_nettype none
package bgi_pkg;
	localparam int MAX_X_POINTS = 64;
	localparam int MAX_Y_POINTS = 64;
	localparam int XIW = $clog2(MAX_X_POINTS);
	localparam int YIW = $clog2(MAX_Y_POINTS);
	localparam int CNTW = 7;
	localparam int GW = XIW + YIW;

	typedef enum logic [1:0] {
		CMD_WR_X    = 2'd0,
		CMD_WR_Y    = 2'd1,
		CMD_WR_GRID = 2'd2,
		CMD_QUERY   = 2'd3
	} cmd_t;

	localparam logic [0:0] REG_X_USED = 1'b0;
	localparam logic [0:0] REG_Y_USED = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_XF, ST_XF_W, ST_XL, ST_XL_W,
		ST_XSCAN, ST_XSCAN_W,
		ST_YF, ST_YF_W, ST_YL, ST_YL_W,
		ST_YSCAN, ST_YSCAN_W,
		ST_XS, ST_XE, ST_XE_W,
		ST_YS, ST_YE, ST_YE_W,
		ST_G0, ST_G1, ST_G2, ST_G3, ST_G3_W,
		ST_LERP, ST_DIV, ST_MUL, ST_MUL_W, ST_ADD,
		ST_DONE
	} state_t;

	// effective count, clamped to 1..MAX
	function automatic logic [CNTW-1:0] eff_cnt(input logic [CNTW-1:0] r, input int mx);
		if (r == '0) return CNTW'(1);
		if (int'(r) > mx) return CNTW'(mx);
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/bilinear_grid_interpolation.sv -----
// Top level: bilinear interpolation over a loaded Q16.16 grid with clamped axes.
// Sequence: a write is stored at its acceptance edge and never raises busy; a query strobes
//   its result after locating the bracket on each axis (a scan over up to 64 points), the
//   axis and grid table reads, and three lerp passes. Writes go back to back while idle; a
//   new query is taken in the cycle after the strobe, and none while busy. Reset: async
//   active low, counts to 64, sequencer idle, memories unset. The receiver cannot stall.
`default_nettype none
module bilinear_grid_interpolation (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire  [1:0]        command,
	input  wire  [5:0]        index_x,
	input  wire  [5:0]        index_y,
	input  wire  signed [31:0] write_value,
	input  wire  signed [31:0] query_x,
	input  wire  signed [31:0] query_y,
	output logic              result_valid,
	output logic signed [31:0] result_value,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [2:0]        paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import bgi_pkg::*;

	// ---------------- configuration registers
	logic [CNTW-1:0] x_used_q, y_used_q;
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_used_q <= CNTW'(64);
			y_used_q <= CNTW'(64);
		end else if (cfg_wr && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_X_USED) x_used_q <= pwdata[CNTW-1:0];
			else                        y_used_q <= pwdata[CNTW-1:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_X_USED) prdata[CNTW-1:0] = x_used_q;
		else                        prdata[CNTW-1:0] = y_used_q;
	end

	// ---------------- memories (registered reads)
	logic signed [31:0] xmem [MAX_X_POINTS];
	logic signed [31:0] ymem [MAX_Y_POINTS];
	logic signed [31:0] gmem [MAX_X_POINTS*MAX_Y_POINTS];
	logic [XIW-1:0] xra;
	logic [YIW-1:0] yra;
	logic [GW-1:0]  gra;
	logic signed [31:0] xrd_q, yrd_q, grd_q;
	logic acc;
	cmd_t cmd;
	assign acc = start && !busy;
	assign cmd = cmd_t'(command);

	always_ff @(posedge clk) begin
		if (acc && cmd == CMD_WR_X)    xmem[index_x[XIW-1:0]] <= write_value;
		if (acc && cmd == CMD_WR_Y)    ymem[index_x[YIW-1:0]] <= write_value;
		if (acc && cmd == CMD_WR_GRID) gmem[{index_x[XIW-1:0], index_y[YIW-1:0]}] <= write_value;
		xrd_q <= xmem[xra];
		yrd_q <= ymem[yra];
		grd_q <= gmem[gra];
	end

	// ---------------- sequencer state
	state_t st_q, st_d;
	logic signed [31:0] qx_q, qy_q;
	logic [CNTW-1:0] nx_q, ny_q;
	logic [XIW-1:0] k_q, sx_q, ex_q;   // k_q: scan pointer
	logic [YIW-1:0] sy_q, ey_q;
	logic signed [31:0] xs_q, xe_q, ys_q, ye_q;    // bracketing axis values
	logic signed [31:0] g00_q, g10_q, g01_q, g11_q, v1_q, v2_q;
	logic [1:0] pass_q;                // 0: v1, 1: v2, 2: final
	logic [6:0] cnt_q;                 // divider/multiplier step count

	// lerp operands for the current pass
	logic signed [31:0] lo_v, hi_v, lo_p, hi_p, cc;
	always_comb begin
		case (pass_q)
			2'd0: begin lo_v = g00_q; hi_v = g10_q; lo_p = xs_q; hi_p = xe_q; cc = qx_q; end
			2'd1: begin lo_v = g01_q; hi_v = g11_q; lo_p = xs_q; hi_p = xe_q; cc = qx_q; end
			default: begin lo_v = v1_q; hi_v = v2_q; lo_p = ys_q; hi_p = ye_q; cc = qy_q; end
		endcase
	end

	// shared divider (restoring, 1 bit/cycle) and multiplier (1 bit/cycle)
	logic [48:0] num_q;      // dividend magnitude / quotient shifting
	logic [32:0] den_q;      // divisor magnitude
	logic [33:0] rem_q;
	logic        neg_q;
	logic [49:0] slope_q;    // |slope|, < 2^49
	logic [33:0] d_q;        // |c - lo_p| multiplier operand
	logic [83:0] prod_q;
	logic signed [41:0] term_q;    // +-2^40 at the cap
	logic signed [32:0] diffv, diffp;
	logic signed [33:0] diffc;
	logic [34:0] rtry;
	assign diffv = 33'(hi_v) - 33'(lo_v);
	assign diffp = 33'(hi_p) - 33'(lo_p);
	assign diffc = 34'(cc) - 34'(lo_p);
	assign rtry  = {rem_q, num_q[48]} - {2'b0, den_q};

	logic signed [41:0] sum;
	logic signed [31:0] sat;
	assign sum = 42'(lo_v) + 42'(term_q);
	always_comb begin
		if (sum > 42'sd2147483647)       sat = 32'h7fffffff;
		else if (sum < -42'sd2147483648) sat = 32'h80000000;
		else                             sat = sum[31:0];
	end

	logic last_x, last_y, gtx, gty;
	assign gtx = qx_q > xrd_q;
	assign gty = qy_q > yrd_q;
	assign last_x = (7'(k_q) == nx_q - 7'd1);
	assign last_y = (7'(k_q) == ny_q - 7'd1);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:    if (acc && cmd == CMD_QUERY) st_d = ST_XF;
			ST_XF:      st_d = ST_XF_W;
			ST_XF_W:    st_d = (!gtx) ? ST_YF : ST_XL;
			ST_XL:      st_d = ST_XL_W;
			// at or above the last point: clamp, else scan
			ST_XL_W:    st_d = (qx_q < xrd_q) ? ST_XSCAN : ST_YF;
			ST_XSCAN:   st_d = ST_XSCAN_W;
			ST_XSCAN_W: st_d = (gtx && !last_x) ? ST_XSCAN : ST_YF;
			ST_YF:      st_d = ST_YF_W;
			ST_YF_W:    st_d = (!gty) ? ST_XS : ST_YL;
			ST_YL:      st_d = ST_YL_W;
			ST_YL_W:    st_d = (qy_q < yrd_q) ? ST_YSCAN : ST_XS;
			ST_YSCAN:   st_d = ST_YSCAN_W;
			ST_YSCAN_W: st_d = (gty && !last_y) ? ST_YSCAN : ST_XS;
			ST_XS:      st_d = ST_XE;
			ST_XE:      st_d = ST_XE_W;
			ST_XE_W:    st_d = ST_YS;
			ST_YS:      st_d = ST_YE;
			ST_YE:      st_d = ST_YE_W;
			ST_YE_W:    st_d = ST_G0;
			ST_G0:      st_d = ST_G1;
			ST_G1:      st_d = ST_G2;
			ST_G2:      st_d = ST_G3;
			ST_G3:      st_d = ST_G3_W;
			ST_G3_W:    st_d = ST_LERP;
			ST_LERP:    st_d = ST_DIV;
			ST_DIV:     if (cnt_q == 7'd48) st_d = ST_MUL;
			ST_MUL:     if (cnt_q == 7'd33) st_d = ST_MUL_W;
			ST_MUL_W:   st_d = ST_ADD;
			ST_ADD:     st_d = (pass_q == 2'd2) ? ST_DONE : ST_LERP;
			ST_DONE:    st_d = ST_IDLE;
			default:    st_d = ST_IDLE;
		endcase
	end

	// read addresses and busy
	always_comb begin
		xra = k_q;
		yra = k_q[YIW-1:0];
		gra = {sx_q, sy_q};
		case (st_q)
			ST_XF, ST_YF: begin xra = '0; yra = '0; end
			ST_XL:        xra = XIW'(nx_q - 7'd1);
			ST_YL:        yra = YIW'(ny_q - 7'd1);
			ST_XS:        xra = sx_q;
			ST_XE:        xra = ex_q;
			ST_YS:        yra = sy_q;
			ST_YE:        yra = ey_q;
			ST_G0:        gra = {sx_q, sy_q};
			ST_G1:        gra = {ex_q, sy_q};
			ST_G2:        gra = {sx_q, ey_q};
			ST_G3:        gra = {ex_q, ey_q};
			default:      ;
		endcase
		busy = (st_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			result_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			result_valid <= (st_q == ST_ADD) && (pass_q == 2'd2);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (acc) begin
				qx_q <= query_x; qy_q <= query_y;
				nx_q <= eff_cnt(x_used_q, MAX_X_POINTS);
				ny_q <= eff_cnt(y_used_q, MAX_Y_POINTS);
				pass_q <= 2'd0;
			end
			ST_XF_W: begin sx_q <= '0; ex_q <= '0; end
			ST_XL_W: begin
				sx_q <= XIW'(nx_q - 7'd1); ex_q <= XIW'(nx_q - 7'd1);
				k_q <= '0;
			end
			ST_XSCAN_W: begin
				if (gtx && !last_x) k_q <= k_q + 1'b1;
				else begin
					ex_q <= k_q;
					sx_q <= (k_q != '0) ? k_q - 1'b1 : '0;
				end
			end
			ST_YF_W: begin sy_q <= '0; ey_q <= '0; end
			ST_YL_W: begin
				sy_q <= YIW'(ny_q - 7'd1); ey_q <= YIW'(ny_q - 7'd1);
				k_q <= '0;
			end
			ST_YSCAN_W: begin
				if (gty && !last_y) k_q <= k_q + 1'b1;
				else begin
					ey_q <= k_q[YIW-1:0];
					sy_q <= (k_q != '0) ? YIW'(k_q - 1'b1) : '0;
				end
			end
			ST_XE: xs_q <= xrd_q;
			ST_XE_W: xe_q <= xrd_q;
			ST_YE: ys_q <= yrd_q;
			ST_YE_W: ye_q <= yrd_q;
			ST_G1: g00_q <= grd_q;
			ST_G2: g10_q <= grd_q;
			ST_G3: g01_q <= grd_q;
			ST_G3_W: g11_q <= grd_q;
			ST_LERP: begin
				// |diffv|<<16 over |diffp|; zero gap gives zero slope
				num_q <= {(diffv[32] ? 33'(-diffv) : 33'(diffv)), 16'h0};
				den_q <= diffp[32] ? 33'(-diffp) : 33'(diffp);
				rem_q <= '0;
				neg_q <= diffv[32] ^ diffp[32];
				cnt_q <= '0;
			end
			ST_DIV: begin
				if (!rtry[34]) begin
					rem_q <= rtry[33:0];
					num_q <= {num_q[47:0], 1'b1};
				end else begin
					rem_q <= {rem_q[32:0], num_q[48]};
					num_q <= {num_q[47:0], 1'b0};
				end
				if (cnt_q == 7'd48) begin
					slope_q <= '0;
					prod_q <= '0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 7'd1;
				end
			end
			ST_MUL: begin
				if (cnt_q == 7'd0) begin
					// latch quotient and |c - lo_p|; sign of product
					slope_q <= (den_q == '0) ? '0 : 50'(num_q);
					d_q <= diffc[33] ? 34'(-diffc) : 34'(diffc);
					neg_q <= ((den_q != '0) && neg_q && (num_q != '0)) ^ diffc[33];
					prod_q <= '0;
				end else begin
					if (d_q[0]) prod_q <= prod_q + (84'(slope_q) << (cnt_q - 7'd1));
					d_q <= d_q >> 1;
				end
				cnt_q <= cnt_q + 7'd1;
			end
			ST_MUL_W: begin
				if (slope_q == '0) term_q <= '0;
				else if (prod_q >= (84'd1 << 56))
					term_q <= neg_q ? -42'sh10000000000 : 42'sh10000000000;
				else if (neg_q) term_q <= -$signed(42'((prod_q + 84'hffff) >> 16));
				else term_q <= $signed(42'(prod_q >> 16));
			end
			ST_ADD: begin
				if (pass_q == 2'd0) v1_q <= sat;
				if (pass_q == 2'd1) v2_q <= sat;
				if (pass_q == 2'd2) result_value <= sat;
				pass_q <= pass_q + 2'd1;
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_busy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !busy) else $error("busy while idle");
	a_res_once: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("double result");
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(st_q) == ST_ADD) else $error("stray result");
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> pass_q != 2'd3) else $error("bad pass");
`endif
endmodule
`default_nettype wire
